### rtl/core/lsc_pkg.sv
// shared types, constants, sine table function and microcode program of the segment counter
package lsc_pkg;

  localparam int LSC_INDEX_BITS      = 12;
  localparam int LSC_SINE_TABLE_BITS = 10;

  localparam int RANGE_W  = 16;
  localparam int ANGLE_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int COORD_W  = 18;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int COUNT_W  = 13;
  localparam int SIN_W    = 16;
  localparam int MUL_W    = 20;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SQ_W     = 35;
  localparam int D2_W     = SQ_W + 1;
  localparam int T2_W     = 2 * CFG_W;
  localparam int Q_SHIFT  = 14;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(4096);

  localparam logic [CFG_W-1:0] RST_MIN_RANGE     = CFG_W'(26);
  localparam logic [CFG_W-1:0] RST_MAX_RANGE     = CFG_W'(7680);
  localparam logic [CFG_W-1:0] RST_START_ANGLE   = CFG_W'(32768);
  localparam logic [CFG_W-1:0] RST_ANGLE_STEP    = CFG_W'(182);
  localparam logic [CFG_W-1:0] RST_GAP_THRESHOLD = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE     = 3'd0,
    REG_MAX_RANGE     = 3'd1,
    REG_START_ANGLE   = 3'd2,
    REG_ANGLE_STEP    = 3'd3,
    REG_GAP_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_WAIT  = 4'd0,
    ST_ANGLE = 4'd1,
    ST_SIN   = 4'd2,
    ST_COS   = 4'd3,
    ST_POINT = 4'd4,
    ST_DX    = 4'd5,
    ST_DY    = 4'd6,
    ST_CMP   = 4'd7,
    ST_EMIT  = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    MUL_IDX_STEP = 3'd0,
    MUL_GAP_SQ   = 3'd1,
    MUL_R_ROM    = 3'd2,
    MUL_DX_SQ    = 3'd3,
    MUL_DY_SQ    = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    OPN_HOLD        = 2'd0,
    OPN_CLEAR       = 2'd1,
    OPN_SET_OUTSIDE = 2'd2,
    OPN_GAP         = 2'd3
  } open_op_t;

  typedef enum logic [2:0] {
    JMP_NONE     = 3'd0,
    JMP_NO_INPUT = 3'd1,
    JMP_INVALID  = 3'd2,
    JMP_OUTSIDE  = 3'd3,
    JMP_OUT_BUSY = 3'd4
  } jmp_cond_t;

  typedef struct packed {
    logic      take;
    mul_sel_t  mul_sel;
    logic      rom_cos;
    logic      ld_angle;
    logic      ld_t2;
    logic      ld_y;
    logic      ld_x;
    logic      ld_d2;
    open_op_t  open_op;
    logic      emit;
    jmp_cond_t cond;
    step_t     branch;
    step_t     next;
  } ucode_t;

  // sine in signed q1.14 from a polynomial over the quadrant, mirrored and negated
  function automatic logic signed [SIN_W-1:0] sine_entry(int unsigned k, int unsigned tbits);
    longint unsigned p;
    longint unsigned quad;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned s;
    p    = (longint'(k) << (16 - tbits)) & 64'hFFFF;
    quad = p >> 14;
    z    = p & 64'h3FFF;
    if ((quad & 64'd1) != 0) z = 64'd16384 - z;
    z2 = (z * z + 64'd8192) >> 14;
    t  = (64'd1160 * z2) >> 14;
    t  = (z2 * (64'd10512 - t)) >> 14;
    s  = (z * (64'd25736 - t) + 64'd8192) >> 14;
    if (s > 64'd16384) s = 64'd16384;
    if ((quad & 64'd2) != 0) return -SIN_W'(s);
    return SIN_W'(s);
  endfunction

  // microcode program: one control word per step
  function automatic ucode_t ucode_word(step_t s);
    ucode_t w;
    w = '0;
    w.branch = ST_WAIT;
    w.next   = ST_WAIT;
    case (s)
      ST_WAIT: begin
        w.take    = 1'b1;
        w.mul_sel = MUL_IDX_STEP;
        w.cond    = JMP_NO_INPUT;
        w.branch  = ST_WAIT;
        w.next    = ST_ANGLE;
      end
      ST_ANGLE: begin
        w.mul_sel  = MUL_GAP_SQ;
        w.ld_angle = 1'b1;
        w.open_op  = OPN_CLEAR;
        w.cond     = JMP_INVALID;
        w.branch   = ST_EMIT;
        w.next     = ST_SIN;
      end
      ST_SIN: begin
        w.ld_t2   = 1'b1;
        w.mul_sel = MUL_R_ROM;
        w.rom_cos = 1'b1;
        w.next    = ST_COS;
      end
      ST_COS: begin
        w.ld_y    = 1'b1;
        w.mul_sel = MUL_R_ROM;
        w.next    = ST_POINT;
      end
      ST_POINT: begin
        w.ld_x    = 1'b1;
        w.open_op = OPN_SET_OUTSIDE;
        w.cond    = JMP_OUTSIDE;
        w.branch  = ST_EMIT;
        w.next    = ST_DX;
      end
      ST_DX: begin
        w.mul_sel = MUL_DX_SQ;
        w.next    = ST_DY;
      end
      ST_DY: begin
        w.ld_d2   = 1'b1;
        w.mul_sel = MUL_DY_SQ;
        w.next    = ST_CMP;
      end
      ST_CMP: begin
        w.open_op = OPN_GAP;
        w.next    = ST_EMIT;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = JMP_OUT_BUSY;
        w.branch = ST_EMIT;
        w.next   = ST_WAIT;
      end
      default: w.next = ST_WAIT;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/lsc_in_if.sv
// input sample channel
interface lsc_in_if
  import lsc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_sample;
  logic               not_number;
  logic               scan_last;

  modport source (output valid, output range_sample, output not_number, output scan_last,
                  input ready);
  modport sink (input valid, input range_sample, input not_number, input scan_last,
                output ready);
endinterface

### rtl/core/lsc_out_if.sv
// result channel
interface lsc_out_if
  import lsc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] segment_count;
  logic               starts_segment;
  logic               point_valid;
  logic               scan_done;

  modport source (output valid, output segment_count, output starts_segment,
                  output point_valid, output scan_done, input ready);
  modport sink (input valid, input segment_count, input starts_segment,
                input point_valid, input scan_done, output ready);
endinterface

### rtl/core/lsc_cfg_if.sv
// configuration write channel
interface lsc_cfg_if
  import lsc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/lidar_scan_segment_counter_unit.sv
// an accepted word passes the angle step; an invalid sample then goes to the emit step,
// one opening a segment after a gap in validity through the sin, cos and point steps,
// one inside a segment also through the dx, dy and compare steps; one sample in flight at
// a time, on the single 20x20 multiplier stepped by the microcode program; emit waits while
// the result register is full, and the result register holds while the next word is taken
// and worked on; synchronous active-low reset restores register defaults and clears scan state
module lidar_scan_segment_counter_unit
  import lsc_pkg::*;
#(
  parameter int INDEX_BITS      = LSC_INDEX_BITS,
  parameter int SINE_TABLE_BITS = LSC_SINE_TABLE_BITS
) (
  input logic      clk,
  input logic      rst_n,
  lsc_in_if.sink   in_if,
  lsc_out_if.source out_if,
  lsc_cfg_if.sink  cfg_if
);

  localparam int SIN_SIZE = 1 << SINE_TABLE_BITS;
  localparam int QUARTER  = SIN_SIZE / 4;

  localparam logic signed [PROD_W-1:0] ROUND_Q14 = PROD_W'(8192);

  // configuration registers
  logic [CFG_W-1:0] min_range_r, max_range_r, start_angle_r, angle_step_r, gap_threshold_r;

  // sequencer
  step_t  step_r, step_nxt;
  ucode_t cw;
  logic   branch_w;
  logic   out_busy_w;
  logic   emit_go;
  logic   in_acc;

  // scan state
  logic [INDEX_BITS-1:0]     sample_index_r;
  logic                      inside_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic [COUNT_W-1:0]        running_count_r, count_nxt;

  // datapath
  logic [RANGE_W-1:0]         r_r;
  logic                       nan_r;
  logic                       last_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic [SINE_TABLE_BITS-1:0] angle_idx_r;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic signed [SIN_W-1:0]    rom_q_r;
  logic [T2_W-1:0]            t2_r;
  logic [SQ_W-1:0]            d2_r;
  logic signed [COORD_W-1:0]  x_r, y_r;
  logic                       opens_r;

  logic [ANGLE_W-1:0]        angle_w;
  logic signed [PROD_W-1:0]  rounded_w;
  logic signed [PROD_W-1:0]  shifted_w;
  logic signed [COORD_W-1:0] coord_w;
  logic signed [DIFF_W-1:0]  dx_w, dy_w;
  logic [D2_W-1:0]           d2_sum_w;
  logic                      gap_w;
  logic                      valid_w;

  // output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_starts_r;
  logic               out_point_r;
  logic               out_done_r;

  logic signed [SIN_W-1:0] sine_rom [SIN_SIZE];

  for (genvar g = 0; g < SIN_SIZE; g++) begin : g_sine
    assign sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  assign cw = ucode_word(step_r);

  assign in_if.ready  = cw.take;
  assign in_acc       = in_if.valid & cw.take;
  assign cfg_if.ready = 1'b1;

  assign valid_w = !nan_r && (r_r > min_range_r) && (r_r < max_range_r);

  assign out_busy_w = out_valid_r & ~out_if.ready;
  assign emit_go    = cw.emit & ~out_busy_w;

  always_comb begin
    case (cw.cond)
      JMP_NONE:     branch_w = 1'b0;
      JMP_NO_INPUT: branch_w = ~in_if.valid;
      JMP_INVALID:  branch_w = ~valid_w;
      JMP_OUTSIDE:  branch_w = ~inside_r;
      JMP_OUT_BUSY: branch_w = out_busy_w;
      default:      branch_w = 1'b0;
    endcase
    step_nxt = branch_w ? cw.branch : cw.next;
  end

  // angle, rom address and q14 scaling of the product
  assign angle_w   = start_angle_r + prod_r[ANGLE_W-1:0];
  assign rom_addr  = cw.rom_cos ? angle_idx_r + SINE_TABLE_BITS'(QUARTER)
                                : angle_w[ANGLE_W-1 -: SINE_TABLE_BITS];
  assign rounded_w = prod_r + ROUND_Q14;
  assign shifted_w = rounded_w >>> Q_SHIFT;
  assign coord_w   = shifted_w[COORD_W-1:0];

  assign dx_w = DIFF_W'(x_r) - DIFF_W'(prev_x_r);
  assign dy_w = DIFF_W'(y_r) - DIFF_W'(prev_y_r);

  assign d2_sum_w = {1'b0, d2_r} + {1'b0, prod_r[SQ_W-1:0]};
  assign gap_w    = d2_sum_w > D2_W'(t2_r);

  always_comb begin
    case (cw.mul_sel)
      MUL_IDX_STEP: begin
        mul_a = MUL_W'(sample_index_r);
        mul_b = MUL_W'(angle_step_r);
      end
      MUL_GAP_SQ: begin
        mul_a = MUL_W'(gap_threshold_r);
        mul_b = MUL_W'(gap_threshold_r);
      end
      MUL_R_ROM: begin
        mul_a = MUL_W'(r_r);
        mul_b = MUL_W'(rom_q_r);
      end
      MUL_DX_SQ: begin
        mul_a = MUL_W'(dx_w);
        mul_b = MUL_W'(dx_w);
      end
      MUL_DY_SQ: begin
        mul_a = MUL_W'(dy_w);
        mul_b = MUL_W'(dy_w);
      end
      default: begin
        mul_a = MUL_W'(sample_index_r);
        mul_b = MUL_W'(angle_step_r);
      end
    endcase
  end

  assign count_nxt = (valid_w && opens_r && running_count_r < COUNT_MAX)
                     ? running_count_r + COUNT_W'(1) : running_count_r;

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    rom_q_r <= sine_rom[rom_addr];
    if (in_acc) begin
      r_r    <= in_if.range_sample;
      nan_r  <= in_if.not_number;
      last_r <= in_if.scan_last;
    end
    if (cw.ld_angle) angle_idx_r <= angle_w[ANGLE_W-1 -: SINE_TABLE_BITS];
    if (cw.ld_t2)    t2_r <= prod_r[T2_W-1:0];
    if (cw.ld_y)     y_r <= coord_w;
    if (cw.ld_x)     x_r <= coord_w;
    if (cw.ld_d2)    d2_r <= prod_r[SQ_W-1:0];
    case (cw.open_op)
      OPN_HOLD:        opens_r <= opens_r;
      OPN_CLEAR:       opens_r <= 1'b0;
      OPN_SET_OUTSIDE: if (!inside_r) opens_r <= 1'b1;
      OPN_GAP:         opens_r <= gap_w;
      default:         opens_r <= opens_r;
    endcase
    if (emit_go) begin
      out_count_r  <= count_nxt;
      out_starts_r <= opens_r;
      out_point_r  <= valid_w;
      out_done_r   <= last_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r     <= RST_MIN_RANGE;
      max_range_r     <= RST_MAX_RANGE;
      start_angle_r   <= RST_START_ANGLE;
      angle_step_r    <= RST_ANGLE_STEP;
      gap_threshold_r <= RST_GAP_THRESHOLD;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MIN_RANGE:     min_range_r     <= cfg_if.data;
        REG_MAX_RANGE:     max_range_r     <= cfg_if.data;
        REG_START_ANGLE:   start_angle_r   <= cfg_if.data;
        REG_ANGLE_STEP:    angle_step_r    <= cfg_if.data;
        REG_GAP_THRESHOLD: gap_threshold_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // step counter, scan state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r          <= ST_WAIT;
      out_valid_r     <= 1'b0;
      sample_index_r  <= '0;
      inside_r        <= 1'b0;
      prev_x_r        <= '0;
      prev_y_r        <= '0;
      running_count_r <= '0;
    end else begin
      step_r <= step_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit_go) begin
        if (last_r) begin
          sample_index_r  <= '0;
          running_count_r <= '0;
          inside_r        <= 1'b0;
          prev_x_r        <= '0;
          prev_y_r        <= '0;
        end else begin
          sample_index_r  <= sample_index_r + INDEX_BITS'(1);
          running_count_r <= count_nxt;
          inside_r        <= valid_w;
          if (valid_w) begin
            prev_x_r <= x_r;
            prev_y_r <= y_r;
          end
        end
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.segment_count  = out_count_r;
  assign out_if.starts_segment = out_starts_r;
  assign out_if.point_valid    = out_point_r;
  assign out_if.scan_done      = out_done_r;

  a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> step_r == ST_ANGLE)
    else $error("accepted word did not start the angle step");

  a_emit_holds_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == ST_EMIT && out_valid_r && !out_if.ready |=> step_r == ST_EMIT)
    else $error("sequencer left the emit step while the result register was full");

  a_scan_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && last_r |=> running_count_r == '0 && sample_index_r == '0 && !inside_r)
    else $error("scan state not cleared after the last sample");

  a_invalid_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && !valid_w |=> !inside_r && out_if.valid && !out_if.starts_segment)
    else $error("invalid sample left a segment open or opened one");

endmodule

### sim/lidar_scan_segment_counter_unit_tb.sv
// self-checking testbench for the lidar scan segment counter, random handshake pacing
module lidar_scan_segment_counter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsc_pkg::*;

  localparam int SINE_BITS      = LSC_SINE_TABLE_BITS;
  localparam int TBL_SIZE       = 1 << SINE_BITS;
  localparam int STALL_PCT      = 37;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int MAX_SHOWN      = 10;
  localparam int RANDOM_ITEMS   = 300;
  localparam int LONG_SCAN_LEN  = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(int'(REG_GAP_THRESHOLD) + 1);

  typedef struct packed {
    logic [RANGE_W-1:0] range_sample;
    logic               not_number;
    logic               scan_last;
  } sample_t;

  typedef struct packed {
    logic [COUNT_W-1:0] segment_count;
    logic               starts_segment;
    logic               point_valid;
    logic               scan_done;
  } seg_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lsc_in_if  in_ch ();
  lsc_out_if out_ch ();
  lsc_cfg_if cfg_ch ();

  lidar_scan_segment_counter_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk = ~clk;

  // expected behavior: register copies and scan state
  int                        sine_tbl [TBL_SIZE];
  logic [CFG_W-1:0]          min_range_m = RST_MIN_RANGE;
  logic [CFG_W-1:0]          max_range_m = RST_MAX_RANGE;
  logic [CFG_W-1:0]          start_m     = RST_START_ANGLE;
  logic [CFG_W-1:0]          step_m      = RST_ANGLE_STEP;
  logic [CFG_W-1:0]          gap_m       = RST_GAP_THRESHOLD;
  logic [LSC_INDEX_BITS-1:0] sample_idx_m = '0;
  logic                      in_seg_m = 1'b0;
  int                        prev_x_m = 0;
  int                        prev_y_m = 0;
  logic [COUNT_W-1:0]        seg_cnt_m = '0;

  sample_t     samples_to_send [$];
  seg_result_t seg_results_due [$];
  seg_result_t seen;
  seg_result_t due;
  sample_t     nxt;

  logic in_taken = 1'b0;
  logic no_idle  = 1'b0;
  int   errors = 0;
  int   results_seen = 0;
  int   scans_done = 0;
  int   openings = 0;
  int   valid_pts = 0;
  int   cfg_writes = 0;
  int   quiet_cycles = 0;
  logic saturated = 1'b0;

  // q1.14 sine over a full turn, polynomial on the quadrant
  function automatic int sine_q14(int unsigned k);
    longint unsigned ph;
    longint unsigned quad;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned s;
    ph   = (longint'(k) << (16 - SINE_BITS)) & 64'hFFFF;
    quad = ph >> 14;
    z    = ph & 64'h3FFF;
    if (quad[0]) z = 64'd16384 - z;
    z2 = (z * z + 64'd8192) >> 14;
    t  = (64'd1160 * z2) >> 14;
    t  = (z2 * (64'd10512 - t)) >> 14;
    s  = (z * (64'd25736 - t) + 64'd8192) >> 14;
    if (s > 64'd16384) s = 64'd16384;
    return quad[1] ? -int'(s) : int'(s);
  endfunction

  // floor of rounded r * c / 2^14
  function automatic int round_q14(logic [RANGE_W-1:0] r, int c);
    longint p;
    p = longint'(r) * longint'(c) + 64'sd8192;
    return int'(p >>> 14);
  endfunction

  function automatic seg_result_t segment_step(sample_t s);
    seg_result_t            res;
    logic [ANGLE_W-1:0]     ang;
    logic [SINE_BITS-1:0]   sidx;
    logic [SINE_BITS-1:0]   cidx;
    int                     x;
    int                     y;
    longint                 dx;
    longint                 dy;
    longint                 d2;
    longint                 t2;
    logic                   ok;
    logic                   opens;
    ok = !s.not_number && s.range_sample > min_range_m && s.range_sample < max_range_m;
    opens = 1'b0;
    if (ok) begin
      ang  = start_m + sample_idx_m * step_m;
      sidx = ang[ANGLE_W-1 -: SINE_BITS];
      cidx = sidx + SINE_BITS'(TBL_SIZE / 4);
      x = round_q14(s.range_sample, sine_tbl[cidx]);
      y = round_q14(s.range_sample, sine_tbl[sidx]);
      if (!in_seg_m) begin
        opens = 1'b1;
      end else begin
        dx = x - prev_x_m;
        dy = y - prev_y_m;
        d2 = dx * dx + dy * dy;
        t2 = longint'(gap_m) * longint'(gap_m);
        opens = d2 > t2;
      end
      if (opens && seg_cnt_m < COUNT_MAX) seg_cnt_m = seg_cnt_m + 1'b1;
      in_seg_m = 1'b1;
      prev_x_m = x;
      prev_y_m = y;
    end else begin
      in_seg_m = 1'b0;
    end
    res.segment_count  = seg_cnt_m;
    res.starts_segment = opens;
    res.point_valid    = ok;
    res.scan_done      = s.scan_last;
    if (s.scan_last) begin
      sample_idx_m = '0;
      seg_cnt_m    = '0;
      in_seg_m     = 1'b0;
      prev_x_m     = 0;
      prev_y_m     = 0;
    end else begin
      sample_idx_m = sample_idx_m + 1'b1;
    end
    return res;
  endfunction

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_MIN_RANGE:     min_range_m = val;
      REG_MAX_RANGE:     max_range_m = val;
      REG_START_ANGLE:   start_m     = val;
      REG_ANGLE_STEP:    step_m      = val;
      REG_GAP_THRESHOLD: gap_m       = val;
      default: ;
    endcase
  endtask

  // checker and expectation builder
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg(cfg_ch.index, cfg_ch.data);
        cfg_writes++;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.segment_count  = out_ch.segment_count;
        seen.starts_segment = out_ch.starts_segment;
        seen.point_valid    = out_ch.point_valid;
        seen.scan_done      = out_ch.scan_done;
        if (seg_results_due.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: unexpected result count=%0d start=%b valid=%b done=%b", $realtime,
                     seen.segment_count, seen.starts_segment, seen.point_valid, seen.scan_done);
        end else begin
          due = seg_results_due.pop_front();
          if (seen.segment_count !== due.segment_count ||
              seen.starts_segment !== due.starts_segment ||
              seen.point_valid !== due.point_valid || seen.scan_done !== due.scan_done) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("%0t: mismatch exp count=%0d start=%b valid=%b done=%b, got %0d %b %b %b",
                       $realtime, due.segment_count, due.starts_segment, due.point_valid,
                       due.scan_done, seen.segment_count, seen.starts_segment,
                       seen.point_valid, seen.scan_done);
          end
          results_seen++;
          if (seen.scan_done) scans_done++;
          if (seen.starts_segment) openings++;
          if (seen.point_valid) valid_pts++;
          if (seen.segment_count == COUNT_MAX) saturated = 1'b1;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        nxt.range_sample = in_ch.range_sample;
        nxt.not_number   = in_ch.not_number;
        nxt.scan_last    = in_ch.scan_last;
        seg_results_due.push_back(segment_step(nxt));
      end
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // sample driver and result-side backpressure
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (samples_to_send.size() > 0 && (no_idle || $urandom_range(99) >= STALL_PCT)) begin
        in_ch.valid        <= 1'b1;
        in_ch.range_sample <= samples_to_send[0].range_sample;
        in_ch.not_number   <= samples_to_send[0].not_number;
        in_ch.scan_last    <= samples_to_send[0].scan_last;
        void'(samples_to_send.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= no_idle || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending", quiet_cycles,
                 seg_results_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic add_sample(int r, logic nan_flag, logic last);
    sample_t s;
    s.range_sample = RANGE_W'(r);
    s.not_number   = nan_flag;
    s.scan_last    = last;
    samples_to_send.push_back(s);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(int lo, int hi, int start, int step, int gap);
    write_reg(REG_MIN_RANGE, CFG_W'(lo));
    write_reg(REG_MAX_RANGE, CFG_W'(hi));
    write_reg(REG_START_ANGLE, CFG_W'(start));
    write_reg(REG_ANGLE_STEP, CFG_W'(step));
    write_reg(REG_GAP_THRESHOLD, CFG_W'(gap));
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (samples_to_send.size() != 0 || seg_results_due.size() != 0 || in_ch.valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // scans of smoothly walking ranges with nan readings, noise and jumps mixed in
  task automatic queue_scans(int n, int lo, int hi);
    int   left;
    int   len;
    int   r;
    int   pick;
    int   i;
    int   v;
    logic nan_flag;
    logic open_window;
    open_window = (hi - lo) >= 2;
    left = n;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      if (len > left) len = left;
      r = open_window ? $urandom_range(lo + 1, hi - 1) : $urandom_range(65535);
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        nan_flag = 1'b0;
        if (pick < 6) begin
          nan_flag = 1'b1;
          v = ($urandom_range(1) == 0) ? r : $urandom_range(65535);
        end else if (pick < 12) begin
          v = $urandom_range(65535);
        end else if (pick < 18) begin
          r = open_window ? $urandom_range(lo + 1, hi - 1) : $urandom_range(65535);
          v = r;
        end else begin
          r = r + int'($urandom_range(64)) - 32;
          if (open_window) begin
            if (r < lo + 1) r = lo + 1;
            if (r > hi - 1) r = hi - 1;
          end else begin
            r = r & 16'hFFFF;
          end
          v = r;
        end
        add_sample(v, nan_flag, (i == len - 1) || ($urandom_range(199) == 0));
      end
      left -= len;
    end
  endtask

  initial begin
    int          k;
    int          lo;
    int          hi;
    int unsigned spare;
    in_ch.valid        = 1'b0;
    in_ch.range_sample = '0;
    in_ch.not_number   = 1'b0;
    in_ch.scan_last    = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    for (k = 0; k < TBL_SIZE; k++) sine_tbl[k] = sine_q14(k);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, on reset register values
    add_sample(0, 1'b0, 1'b0);
    add_sample(int'(RST_MIN_RANGE), 1'b0, 1'b0);
    add_sample(int'(RST_MIN_RANGE) + 1, 1'b0, 1'b0);
    add_sample(int'(RST_MIN_RANGE) + 1, 1'b0, 1'b0);
    add_sample(int'(RST_MAX_RANGE) - 1, 1'b0, 1'b0);
    add_sample(int'(RST_MAX_RANGE), 1'b0, 1'b0);
    add_sample(65535, 1'b0, 1'b0);
    add_sample(4000, 1'b1, 1'b0);
    add_sample(4000, 1'b0, 1'b0);
    add_sample(4100, 1'b0, 1'b0);
    add_sample(4400, 1'b0, 1'b0);
    add_sample(4400, 1'b0, 1'b1);
    add_sample(4400, 1'b0, 1'b0);
    add_sample(65535, 1'b1, 1'b1);
    add_sample(1000, 1'b0, 1'b1);
    add_sample(0, 1'b1, 1'b0);
    add_sample(65535, 1'b0, 1'b0);
    add_sample(int'(RST_MAX_RANGE) - 1, 1'b0, 1'b1);
    wait_quiet();

    // typical window, plus writes to unused indexes that must be ignored
    lo = $urandom_range(10, 500);
    hi = $urandom_range(5000, 20000);
    set_config(lo, hi, $urandom_range(65535), $urandom_range(50, 400), $urandom_range(64, 1024));
    for (spare = REG_SPARE_FIRST; spare < (1 << CFG_IDX_W); spare++)
      write_reg(CFG_IDX_W'(spare), CFG_W'($urandom_range(65535)));
    end_writes();
    queue_scans(RANDOM_ITEMS, lo, hi);
    wait_quiet();

    // widest window, top angles and threshold
    set_config(0, 65535, 65535, 65535, 65535);
    end_writes();
    queue_scans(RANDOM_ITEMS, 0, 65535);
    wait_quiet();

    // inverted window, zero angles and threshold: nothing is valid
    set_config(65535, 0, 0, 0, 0);
    end_writes();
    queue_scans(100, 65535, 0);
    wait_quiet();

    // empty window of adjacent bounds
    set_config(100, 101, $urandom_range(65535), $urandom_range(65535), 0);
    end_writes();
    queue_scans(50, 100, 101);
    wait_quiet();

    // a single legal range value
    set_config(100, 102, $urandom_range(65535), $urandom_range(1, 2000), 0);
    end_writes();
    queue_scans(50, 100, 102);
    wait_quiet();

    // one long scan at full rate, nearly every sample opens a segment
    no_idle = 1'b1;
    set_config(0, 65535, 0, 1, 0);
    end_writes();
    for (k = 0; k < LONG_SCAN_LEN; k++)
      add_sample($urandom_range(1, 65534), 1'b0, k == LONG_SCAN_LEN - 1);
    wait_quiet();
    no_idle = 1'b0;

    repeat (3) begin
      lo = $urandom_range(0, 2000);
      hi = $urandom_range(lo + 2, 65535);
      set_config(lo, hi, $urandom_range(65535), $urandom_range(2000), $urandom_range(2000));
      end_writes();
      queue_scans(RANDOM_ITEMS, lo, hi);
      wait_quiet();
    end

    $display("checked %0d results in %0d scans: %0d valid points, %0d segment openings",
             results_seen, scans_done, valid_pts, openings);
    $display("%0d register writes, count saturation %s", cfg_writes,
             saturated ? "reached" : "not reached");
    if (errors == 0 && seg_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, seg_results_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lsc_pkg.sv
rtl/core/lsc_in_if.sv
rtl/core/lsc_out_if.sv
rtl/core/lsc_cfg_if.sv
rtl/core/lidar_scan_segment_counter_unit.sv
sim/lidar_scan_segment_counter_unit_tb.sv
